// ===== rtl/core/crcw_pkg.sv =====
// Shared types, constants and the byte-step function of the CRC-64 word accumulator.
// Has no dependencies; every other file of the block but crcw_queue imports it.
`default_nettype none

package crcw_pkg;

  localparam int unsigned CRC_W       = 64;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned COUNT_W     = 4;
  localparam logic [COUNT_W-1:0] MAX_BYTES = 4'd8;
  localparam logic [CRC_W-1:0]   CRC_INIT  = 64'hffff_ffff_ffff_ffff;

  // One input item after the front end has clamped its byte count.
  typedef struct packed {
    logic                 start_req;
    logic [CRC_W-1:0]     data;
    logic [COUNT_W-1:0]   byte_count;
  } crcw_item_t;

  // One reflected CRC byte step. The table entry is formed bit by bit from the
  // polynomial, which is the same as looking it up in the right-shifting table.
  function automatic logic [CRC_W-1:0] crcw_byte_step(
    input logic [CRC_W-1:0]  crc,
    input logic [BYTE_W-1:0] data_byte,
    input logic [CRC_W-1:0]  poly
  );
    logic [CRC_W-1:0] v;
    v = {{(CRC_W-BYTE_W){1'b0}}, crc[BYTE_W-1:0] ^ data_byte};
    for (int k = 0; k < BYTE_W; k++) begin
      if (v[0]) begin
        v = (v >> 1) ^ poly;
      end else begin
        v = v >> 1;
      end
    end
    return (crc >> BYTE_W) ^ v;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/crc64_word_accumulator.sv =====
// Top level of the running reflected CRC-64 accumulator.
// Depends on crcw_pkg, crcw_front, crcw_queue and crcw_back.
//
// Usage:
//   Input channel: the host presents start_req, data and byte_count and raises
//   in_push; a transfer happens at a clock edge where in_push is high and in_full
//   is low. Bytes of data are consumed least significant first; byte_count picks
//   how many (zero processes none, above eight means eight). start_req reloads
//   the CRC register with all ones before the item's bytes.
//   Result channel: while out_empty is low, out_crc_value is the CRC after the
//   oldest unread item; out_pop high at such an edge completes the transfer.
//   Configuration: cfg_reflected_polynomial is written on cfg_valid (cfg_ready is
//   always high). Write it only while no item is in flight.
//   Throughput: the CRC engine does one byte per cycle, except that the last byte
//   step of an item waits while the result queue is full. An input transfer passes
//   the front register, the item queue and the engine in that order; the engine
//   writes the result queue on the item's last step, and out_empty falls once
//   the result queue has registered that write.
//   Reset clears all queues, sets the CRC register to all ones and the polynomial
//   to zero. When the receiver stalls, the result queue fills, then the engine
//   holds its last step, then the item queue and front register fill, and only
//   then in_full rises.
`default_nettype none

module crc64_word_accumulator #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_push,
  output logic                               in_full,
  input  wire logic                          in_start_req,
  input  wire logic [crcw_pkg::CRC_W-1:0]    in_data,
  input  wire logic [crcw_pkg::COUNT_W-1:0]  in_byte_count,
  output logic                               out_empty,
  input  wire logic                          out_pop,
  output logic [crcw_pkg::CRC_W-1:0]         out_crc_value,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [crcw_pkg::CRC_W-1:0]    cfg_reflected_polynomial
);

  import crcw_pkg::*;

  logic [CRC_W-1:0] poly_r, poly_nxt;

  logic             fe_valid;
  crcw_item_t       fe_item;
  logic             fe_ready;

  logic             q_valid;
  crcw_item_t       q_item;
  logic             q_pop;

  logic             res_push;
  logic [CRC_W-1:0] res_crc;
  logic             res_ready;
  logic             res_valid;

  // The configuration channel never stalls.
  assign cfg_ready = 1'b1;
  assign poly_nxt  = (cfg_valid && cfg_ready) ? cfg_reflected_polynomial : poly_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poly_r <= '0;
    end else begin
      poly_r <= poly_nxt;
    end
  end

  crcw_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_start_req  (in_start_req),
    .in_data       (in_data),
    .in_byte_count (in_byte_count),
    .item_valid    (fe_valid),
    .item          (fe_item),
    .item_ready    (fe_ready)
  );

  // Items waiting for the engine.
  crcw_queue #(
    .WIDTH ($bits(crcw_item_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_item_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (fe_valid),
    .push_data  (fe_item),
    .push_ready (fe_ready),
    .pop        (q_pop),
    .pop_data   (q_item),
    .pop_valid  (q_valid)
  );

  crcw_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .poly       (poly_r),
    .item_valid (q_valid),
    .item       (q_item),
    .item_pop   (q_pop),
    .res_push   (res_push),
    .res_crc    (res_crc),
    .res_ready  (res_ready)
  );

  // Finished results, so the engine keeps going while the receiver stalls.
  crcw_queue #(
    .WIDTH (CRC_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_result_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (res_push),
    .push_data  (res_crc),
    .push_ready (res_ready),
    .pop        (out_pop),
    .pop_data   (out_crc_value),
    .pop_valid  (res_valid)
  );

  assign out_empty = !res_valid;

endmodule

`default_nettype wire

// ===== rtl/core/crcw_queue.sv =====
// Small register-based first-in first-out queue with combinational read data.
// Depends on nothing; used between the front and back ends and for results.
`default_nettype none

module crcw_queue #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  push_ready,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      pop_data,
  output logic                  pop_valid
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count_r != FULL_CNT);
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/crcw_front.sv =====
// Front end: takes input transfers into a holding register and clamps the byte count.
// Depends on crcw_pkg; feeds the item queue.
`default_nettype none

module crcw_front (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_push,
  output logic                               in_full,
  input  wire logic                          in_start_req,
  input  wire logic [crcw_pkg::CRC_W-1:0]    in_data,
  input  wire logic [crcw_pkg::COUNT_W-1:0]  in_byte_count,
  output logic                               item_valid,
  output crcw_pkg::crcw_item_t               item,
  input  wire logic                          item_ready
);

  import crcw_pkg::*;

  crcw_item_t item_r, item_nxt;
  logic       valid_r, valid_nxt;
  logic       accept;

  assign in_full    = valid_r && !item_ready;
  assign accept     = in_push && !in_full;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_comb begin
    item_nxt            = item_r;
    valid_nxt           = valid_r && !item_ready;
    if (accept) begin
      item_nxt.start_req  = in_start_req;
      item_nxt.data       = in_data;
      // Counts above eight behave as a full word.
      item_nxt.byte_count = (in_byte_count > MAX_BYTES) ? MAX_BYTES : in_byte_count;
      valid_nxt           = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

endmodule

`default_nettype wire

// ===== rtl/core/crcw_back.sv =====
// Back end: byte-serial CRC engine that holds the running CRC and emits one result per item.
// Depends on crcw_pkg; reads the item queue and writes the result queue.
`default_nettype none

module crcw_back (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic [crcw_pkg::CRC_W-1:0]  poly,
  input  wire logic                        item_valid,
  input  wire crcw_pkg::crcw_item_t        item,
  output logic                             item_pop,
  output logic                             res_push,
  output logic [crcw_pkg::CRC_W-1:0]       res_crc,
  input  wire logic                        res_ready
);

  import crcw_pkg::*;

  logic [CRC_W-1:0]   crc_r, crc_nxt;
  logic [CRC_W-1:0]   data_r, data_nxt;
  logic [COUNT_W-1:0] rem_r, rem_nxt;
  logic               busy_r, busy_nxt;
  logic [CRC_W-1:0]   step_crc;
  logic [CRC_W-1:0]   result;
  logic               finishing;
  logic               done;
  logic               take;

  assign step_crc  = crcw_byte_step(crc_r, data_r[BYTE_W-1:0], poly);
  // The last byte step and the result write share a cycle; an item with no
  // bytes reports the register as it stands.
  assign finishing = busy_r && (rem_r <= COUNT_W'(1));
  assign result    = (rem_r == '0) ? crc_r : step_crc;
  assign done      = finishing && res_ready;
  assign take      = item_valid && (!busy_r || done);

  assign res_push  = done;
  assign res_crc   = result;
  assign item_pop  = take;

  always_comb begin
    crc_nxt  = crc_r;
    data_nxt = data_r;
    rem_nxt  = rem_r;
    busy_nxt = busy_r;
    if (take) begin
      if (item.start_req) begin
        crc_nxt = CRC_INIT;
      end else if (done) begin
        crc_nxt = result;
      end
      data_nxt = item.data;
      rem_nxt  = item.byte_count;
      busy_nxt = 1'b1;
    end else if (done) begin
      crc_nxt  = result;
      busy_nxt = 1'b0;
    end else if (busy_r && (rem_r > COUNT_W'(1))) begin
      crc_nxt  = step_crc;
      data_nxt = data_r >> BYTE_W;
      rem_nxt  = rem_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r  <= CRC_INIT;
      busy_r <= 1'b0;
      rem_r  <= '0;
    end else begin
      crc_r  <= crc_nxt;
      busy_r <= busy_nxt;
      rem_r  <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

endmodule

`default_nettype wire

// ===== test/crc64_word_accumulator_tb.sv =====
// Self-checking testbench for crc64_word_accumulator, the running reflected CRC-64 block.
// Depends on crcw_pkg for widths and constants and on the RTL of the block; nothing else.
`timescale 1ns / 1ps

module crc64_word_accumulator_tb;
  import crcw_pkg::*;

  // The run is stopped here if the block hangs. The slowest correct run is far below this.
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam logic [CRC_W-1:0] POLY_ECMA   = 64'hc96c_5795_d787_0f42;
  localparam logic [CRC_W-1:0] POLY_ISO    = 64'hd800_0000_0000_0000;
  localparam logic [CRC_W-1:0] ALL_ONES    = 64'hffff_ffff_ffff_ffff;
  localparam int unsigned PRESSURE_HOLD = 200;
  localparam int unsigned PRESSURE_ITEMS = 40;
  localparam int unsigned RANDOM_PHASES = 6;
  localparam int unsigned ITEMS_PER_PHASE = 280;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_push = 1'b0;
  logic                 in_full;
  logic                 in_start_req = 1'b0;
  logic [CRC_W-1:0]     in_data = '0;
  logic [COUNT_W-1:0]   in_byte_count = '0;
  logic                 out_empty;
  logic                 out_pop = 1'b0;
  logic [CRC_W-1:0]     out_crc_value;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CRC_W-1:0]     cfg_reflected_polynomial = '0;

  // Predictor state: the running CRC and the byte table of the current polynomial.
  logic [CRC_W-1:0]     model_crc;
  logic [CRC_W-1:0]     byte_table [0:255];
  // CRC values the block owes us, oldest first.
  logic [CRC_W-1:0]     pending_crc_q [$];
  logic [CRC_W-1:0]     head_crc;
  int unsigned          mismatch_count = 0;
  int unsigned          cycle_count = 0;
  // Random idling on both sides is switched off for some stretches.
  bit                   idling_on = 1'b1;
  // A nonzero value asks the receiver to hold off; the receiver counts it down.
  int unsigned          hold_request = 0;

  crc64_word_accumulator DUT (
    .clk                      (clk),
    .rst_n                    (rst_n),
    .in_push                  (in_push),
    .in_full                  (in_full),
    .in_start_req             (in_start_req),
    .in_data                  (in_data),
    .in_byte_count            (in_byte_count),
    .out_empty                (out_empty),
    .out_pop                  (out_pop),
    .out_crc_value            (out_crc_value),
    .cfg_valid                (cfg_valid),
    .cfg_ready                (cfg_ready),
    .cfg_reflected_polynomial (cfg_reflected_polynomial)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Rebuilds the 256-entry right-shifting table for a new reflected polynomial.
  function automatic void set_model_poly(input logic [CRC_W-1:0] poly);
    logic [CRC_W-1:0] v;
    for (int i = 0; i < 256; i++) begin
      v = {{(CRC_W-8){1'b0}}, 8'(i)};
      for (int b = 0; b < 8; b++) begin
        v = v[0] ? ((v >> 1) ^ poly) : (v >> 1);
      end
      byte_table[i] = v;
    end
  endfunction

  // Mostly back-to-back, sometimes a short pause, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!idling_on || r < 60) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  // Offers one item and waits for its transfer, then predicts the CRC it must produce.
  // With no gap the push stays high, so the next item follows unless in_full holds it.
  task automatic send_item(input logic start, input logic [CRC_W-1:0] data,
                           input logic [COUNT_W-1:0] count);
    logic [CRC_W-1:0] crc;
    int unsigned      nbytes;
    int unsigned      gap;
    @(negedge clk);
    in_start_req  <= start;
    in_data       <= data;
    in_byte_count <= count;
    in_push       <= 1'b1;
    do @(posedge clk); while (in_full);
    crc    = start ? CRC_INIT : model_crc;
    nbytes = 32'((count > MAX_BYTES) ? MAX_BYTES : count);
    for (int k = 0; k < nbytes; k++) begin
      crc = (crc >> 8) ^ byte_table[crc[7:0] ^ data[8*k +: 8]];
    end
    model_crc = crc;
    pending_crc_q.push_back(crc);
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk) in_push <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Random content shaped like the host's traffic: mostly full 64-bit words, some 32-bit
  // fields and single bytes, a few odd counts including zero and values above eight.
  task automatic send_random_item();
    logic [COUNT_W-1:0] count;
    int unsigned        r;
    r = $urandom_range(0, 9);
    if (r < 6) begin
      count = 4'd8;
    end else if (r == 6) begin
      count = 4'd4;
    end else if (r == 7) begin
      count = 4'd1;
    end else if (r == 8) begin
      count = COUNT_W'($urandom_range(0, 15));
    end else begin
      count = COUNT_W'($urandom_range(2, 7));
    end
    send_item($urandom_range(0, 15) == 0, {$urandom(), $urandom()}, count);
  endtask

  // Stops offering items and waits until every owed result has been taken, plus a short
  // margin so the engine is surely at rest before the polynomial changes.
  task automatic wait_idle();
    @(negedge clk) in_push <= 1'b0;
    while (pending_crc_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_poly(input logic [CRC_W-1:0] poly);
    wait_idle();
    @(negedge clk);
    cfg_valid                <= 1'b1;
    cfg_reflected_polynomial <= poly;
    do @(posedge clk); while (!cfg_ready);
    set_model_poly(poly);
    @(negedge clk) cfg_valid <= 1'b0;
  endtask

  // The reset polynomial is zero, so the table is empty and each byte only shifts.
  task automatic test_zero_polynomial();
    send_item(1'b1, ALL_ONES, 4'd8);
    send_item(1'b0, 64'h0123_4567_89ab_cdef, 4'd3);
    send_item(1'b1, 64'h0, 4'd0);
  endtask

  task automatic test_directed_cases();
    write_poly(POLY_ECMA);
    // The classic check string "123456789" as one word and one trailing byte.
    send_item(1'b1, 64'h3837_3635_3433_3231, 4'd8);
    send_item(1'b0, 64'h39, 4'd1);
    send_item(1'b1, 64'h0, 4'd8);
    send_item(1'b1, ALL_ONES, 4'd8);
    send_item(1'b0, ALL_ONES, 4'd1);
    // Zero byte count: a start still reloads, and without start nothing changes.
    send_item(1'b1, 64'h5555_5555_5555_5555, 4'd0);
    send_item(1'b0, 64'hdead_beef_cafe_f00d, 4'd0);
    // Counts above eight are taken as eight.
    send_item(1'b0, 64'haaaa_aaaa_aaaa_aaaa, 4'd9);
    send_item(1'b0, 64'h8000_0000_0000_0001, 4'd15);
    send_item(1'b0, 64'h0000_0000_8765_4321, 4'd4);
    send_item(1'b0, 64'h8000_0000_0000_0000, 4'd8);
  endtask

  task automatic test_polynomial_extremes();
    write_poly(ALL_ONES);
    send_item(1'b1, 64'hfedc_ba98_7654_3210, 4'd8);
    send_item(1'b0, ALL_ONES, 4'd8);
    send_item(1'b0, 64'h0, 4'd7);
    write_poly(64'h1);
    send_item(1'b1, 64'h0f0f_0f0f_f0f0_f0f0, 4'd8);
    send_item(1'b0, 64'h7f, 4'd2);
    write_poly(POLY_ISO);
    send_item(1'b1, 64'h1234_5678_9abc_def0, 4'd8);
    send_item(1'b0, 64'h0, 4'd5);
  endtask

  // The receiver holds off while the sender keeps pushing back to back, so the result
  // queue, the engine, the item queue and the front register fill and in_full rises.
  task automatic test_backpressure();
    write_poly(POLY_ECMA);
    idling_on = 1'b0;
    @(posedge clk);
    hold_request = PRESSURE_HOLD;
    send_item(1'b1, {$urandom(), $urandom()}, 4'd8);
    repeat (PRESSURE_ITEMS - 1) send_random_item();
    idling_on = 1'b1;
  endtask

  // Several phases, each under its own polynomial; one phase runs without any idling.
  task automatic test_random_traffic();
    logic [CRC_W-1:0] poly;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0:       poly = POLY_ECMA;
        3:       poly = ALL_ONES;
        default: poly = {$urandom(), $urandom()};
      endcase
      write_poly(poly);
      idling_on = (phase != 2);
      send_item(1'b1, {$urandom(), $urandom()}, 4'd8);
      repeat (ITEMS_PER_PHASE - 1) send_random_item();
    end
    idling_on = 1'b1;
  endtask

  // Receiver: pops with random gaps, and honors a requested long hold-off by counting it
  // down here at each falling edge.
  initial begin
    int unsigned stall;
    stall = 0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        stall        = hold_request;
        hold_request = 0;
      end
      if (stall > 0) begin
        out_pop <= 1'b0;
        stall--;
      end else begin
        out_pop <= 1'b1;
        stall = pick_gap();
      end
    end
  end

  // Every result transfer is matched against the oldest owed CRC.
  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      if (pending_crc_q.size() == 0) begin
        mismatch_count++;
        $error("crc_value: no result expected, actual %h", out_crc_value);
      end else begin
        head_crc = pending_crc_q.pop_front();
        if (out_crc_value !== head_crc) begin
          mismatch_count++;
          $error("crc_value: expected %h, actual %h", head_crc, out_crc_value);
        end
      end
    end
  end

  // Watchdog for a hung handshake.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("crc64_word_accumulator_tb: FAIL");
    $finish;
  end

  initial begin
    model_crc = CRC_INIT;
    set_model_poly('0);
    repeat (5) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    test_zero_polynomial();
    test_directed_cases();
    test_polynomial_extremes();
    test_backpressure();
    test_random_traffic();

    wait_idle();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("crc64_word_accumulator_tb: PASS");
    end else begin
      $display("crc64_word_accumulator_tb: FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/crcw_pkg.sv
rtl/core/crcw_queue.sv
rtl/core/crcw_front.sv
rtl/core/crcw_back.sv
rtl/core/crc64_word_accumulator.sv
test/crc64_word_accumulator_tb.sv
